// ===== rtl/core/ppu_pkg.sv =====
// ppu_pkg: shared constants, types and helpers of the particle pool update block
`default_nettype none

package ppu_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_OUT_W = 6;
  localparam int SPAWN_W    = 3;
  localparam int LIFE_W     = 18;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;

  localparam logic [SPAWN_W-1:0] SPAWN_MAX   = 3'd4;
  localparam logic [SPAWN_W-1:0] SPAWN_RESET = 3'd2;

  localparam logic signed [LIFE_W-1:0] LIFE_ONE   = 18'sd65536;
  localparam logic signed [LIFE_W-1:0] LIFE_FLOOR = -18'sd65536;

  // reciprocals for the constant divides, exact over the operand ranges used
  localparam logic [23:0] RECIP_100    = 24'd10737419;
  localparam int          RECIP_100_SH = 30;
  localparam logic [31:0] RECIP_10     = 32'd3435973837;
  localparam int          RECIP_10_SH  = 35;

  localparam logic [7:0]  SHADE_BASE  = 8'd50;
  localparam logic [7:0]  SHADE_RESET = 8'd100;
  localparam logic [16:0] ALPHA_RESET = 17'd65536;

  localparam logic signed [33:0] POS_MAX = 34'sd2147483647;
  localparam logic signed [33:0] POS_MIN = -34'sd2147483648;

  typedef struct packed {
    logic signed [LIFE_W-1:0] life;
    logic [2:0][31:0]         pos;
    logic [2:0][31:0]         vel;
    logic [7:0]               shade;
    logic [16:0]              alpha;
  } slot_rec_t;

  localparam slot_rec_t REC_RESET = '{
    life:  LIFE_ONE,
    pos:   '0,
    vel:   '0,
    shade: SHADE_RESET,
    alpha: ALPHA_RESET
  };

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic [2:0][31:0]      pos;
    logic [16:0]           alpha;
    logic [7:0]            brightness;
    logic                  alive;
    logic                  last;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE_MUL,
    ST_PRE_FIN,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_SPN_RD,
    ST_SPN_WR,
    ST_SWP_RD,
    ST_SWP_LIFE,
    ST_SWP_MUL,
    ST_SWP_ACC,
    ST_SWP_EMIT
  } ppu_state_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] res;
    if (v > POS_MAX) begin
      res = 32'h7FFF_FFFF;
    end else if (v < POS_MIN) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ppu_if.sv =====
// ppu_if: valid/ready channel interfaces for frame ticks and slot results
`default_nettype none

interface ppu_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        dt;
  logic signed [31:0] target_pos_x;
  logic signed [31:0] target_pos_y;
  logic signed [31:0] target_pos_z;
  logic signed [31:0] target_vel_x;
  logic signed [31:0] target_vel_y;
  logic signed [31:0] target_vel_z;
  logic signed [6:0]  offset_first;
  logic [6:0]         shade_first;
  logic signed [6:0]  offset_second;
  logic [6:0]         shade_second;

  modport source (
    output valid, dt, target_pos_x, target_pos_y, target_pos_z,
           target_vel_x, target_vel_y, target_vel_z,
           offset_first, shade_first, offset_second, shade_second,
    input  ready
  );

  modport sink (
    input  valid, dt, target_pos_x, target_pos_y, target_pos_z,
           target_vel_x, target_vel_y, target_vel_z,
           offset_first, shade_first, offset_second, shade_second,
    output ready
  );
endinterface

interface ppu_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         slot;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic [16:0]        alpha;
  logic [7:0]         brightness;
  logic               alive;
  logic               last;

  modport source (
    output valid, slot, out_pos_x, out_pos_y, out_pos_z, alpha, brightness, alive, last,
    input  ready
  );

  modport sink (
    input  valid, slot, out_pos_x, out_pos_y, out_pos_z, alpha, brightness, alive, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/ppu_mul.sv =====
// ppu_mul: shared signed multiplier with a registered product
`default_nettype none

module ppu_mul (
  input  logic                                clk,
  input  logic signed [ppu_pkg::MUL_W-1:0]    a,
  input  logic signed [ppu_pkg::MUL_W-1:0]    b,
  output logic signed [ppu_pkg::PROD_W-1:0]   p
);
  import ppu_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign p = prod_r;

endmodule

`default_nettype wire

// ===== rtl/core/particle_pool_update_top.sv =====
// particle_pool_update_top: particle pool respawn and per-slot update sequencer
//
//  channel  dir  handshake          word
//  in_ch    in   valid/ready        one frame tick: dt, target pos/vel, spawn randoms
//  out_ch   out  valid/ready        one slot result: slot, pos, alpha, brightness, flags
//  cfg      in   cfg_we, no wait    spawn_per_tick
//
// a tick first scales the spawn offsets and target velocity by reciprocals on the
// shared multiplier, then per spawn searches for a dead slot (one memory read per
// searched slot) and writes it, then updates every slot: a live slot gets one
// multiply/subtract pass per axis, a dead slot none. reset is synchronous; per-slot
// valid bits make unwritten slots read as reset values. in_ready is high only when
// idle; out_ready low holds the sweep at the emit step while a result is pending.
`default_nettype none

module particle_pool_update_top (
  input  logic                             clk,
  input  logic                             rst_n,
  ppu_in_if.sink                           in_ch,
  ppu_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [ppu_pkg::SPAWN_W-1:0]      cfg_data
);
  import ppu_pkg::*;

  localparam logic [2:0] PRE_OFF1 = 3'd0;
  localparam logic [2:0] PRE_OFF2 = 3'd1;
  localparam logic [2:0] PRE_VX   = 3'd2;
  localparam logic [2:0] PRE_LAST = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

  ppu_state_t state_r, state_nxt;

  logic [SPAWN_W-1:0] spawn_r;
  logic [SPAWN_W-1:0] nspawn_r, nspawn_nxt;
  logic [SPAWN_W-1:0] kcnt_r, kcnt_nxt;
  logic [2:0]         pcnt_r, pcnt_nxt;
  logic [1:0]         ax_r, ax_nxt;
  logic [SLOT_W-1:0]  idx_r, idx_nxt;
  logic [SLOT_W-1:0]  scnt_r, scnt_nxt;
  logic [SLOT_W-1:0]  sstart_r, sstart_nxt;
  logic [SLOT_W-1:0]  tgt_r, tgt_nxt;
  logic [SLOT_W-1:0]  idx_inc;

  // latched tick
  logic [15:0]       dt_r;
  logic [2:0][31:0]  tpos_r;
  logic [2:0][31:0]  tvel_r;
  logic [6:0]        off1_r, off2_r, shade1_r, shade2_r;
  logic              in_acc;

  // per-tick spawn values
  logic signed [17:0] offq1_r, offq2_r;
  logic [2:0][31:0]   svel_r;
  logic               pre_we;

  // slot memory
  slot_rec_t         slot_mem [SLOTS];
  slot_rec_t         rd_q_r;
  logic              rd_vld_r;
  logic [SLOTS-1:0]  valid_r;
  logic              rd_en, wr_en;
  logic [SLOT_W-1:0] rd_addr, wr_addr;
  slot_rec_t         wr_rec;
  slot_rec_t         rec_rd;

  slot_rec_t wrec_r, wrec_nxt;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_r, out_nxt;
  logic      emit_go;

  // shared multiplier
  logic signed [MUL_W-1:0]  ma, mb;
  logic signed [PROD_W-1:0] prod;

  // scaling helpers
  logic [6:0]         pre_off, pre_off_mag;
  logic               pre_off_neg, pre_is_off;
  logic [1:0]         pax;
  logic [31:0]        pre_vel, pre_vel_mag;
  logic               pre_vel_neg;
  logic [16:0]        q_off;
  logic [27:0]        q_vel;
  logic signed [17:0] pre_offq;
  logic [31:0]        pre_svel;

  // spawn and sweep helpers
  logic signed [17:0] sp_offq;
  logic [6:0]         sp_shade;
  logic signed [18:0] life_dif;
  logic signed [17:0] life_n;
  logic [48:0]        msum;
  logic signed [32:0] mv;
  logic signed [33:0] pos_dif;

  ppu_mul u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (prod)
  );

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign rec_rd      = rd_vld_r ? rd_q_r : REC_RESET;
  assign idx_inc     = (idx_r == SLOT_LAST) ? '0 : idx_r + 1'b1;
  assign emit_go     = !out_valid_r || out_ch.ready;

  // scaling operands: offsets by 1/100, target velocity by 1/10, both rounded
  always_comb begin
    pre_is_off  = (pcnt_r < PRE_VX);
    pre_off     = (pcnt_r == PRE_OFF1) ? off1_r : off2_r;
    pre_off_neg = pre_off[6];
    pre_off_mag = pre_off_neg ? 7'(-pre_off) : pre_off;
    pax         = pre_is_off ? 2'd0 : 2'(pcnt_r - PRE_VX);
    pre_vel     = tvel_r[pax];
    pre_vel_neg = pre_vel[31];
    pre_vel_mag = pre_vel_neg ? 32'(-pre_vel) : pre_vel;
    q_off       = prod[RECIP_100_SH+16:RECIP_100_SH];
    q_vel       = prod[RECIP_10_SH+27:RECIP_10_SH];
    pre_offq    = pre_off_neg ? -$signed({1'b0, q_off}) : $signed({1'b0, q_off});
    pre_svel    = pre_vel_neg ? 32'(-{4'd0, q_vel}) : {4'd0, q_vel};
  end

  always_comb begin
    sp_offq  = (kcnt_r == '0) ? offq1_r : offq2_r;
    sp_shade = (kcnt_r == '0) ? shade1_r : shade2_r;
    life_dif = $signed({rec_rd.life[LIFE_W-1], rec_rd.life}) - $signed({3'd0, dt_r});
    life_n   = (life_dif < $signed({LIFE_FLOOR[LIFE_W-1], LIFE_FLOOR})) ?
               LIFE_FLOOR : life_dif[LIFE_W-1:0];
    // vel*dt rounded to Q16.16, ties toward plus infinity
    msum     = {prod[47], prod[47:0]} + 49'd32768;
    mv       = msum[48:16];
    pos_dif  = $signed({{2{wrec_r.pos[ax_r][31]}}, wrec_r.pos[ax_r]}) -
               $signed({mv[32], mv});
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    nspawn_nxt    = nspawn_r;
    kcnt_nxt      = kcnt_r;
    pcnt_nxt      = pcnt_r;
    ax_nxt        = ax_r;
    idx_nxt       = idx_r;
    scnt_nxt      = scnt_r;
    sstart_nxt    = sstart_r;
    tgt_nxt       = tgt_r;
    wrec_nxt      = wrec_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_rec        = wrec_r;
    ma            = '0;
    mb            = '0;
    pre_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          nspawn_nxt = (spawn_r > SPAWN_MAX) ? SPAWN_MAX : spawn_r;
          kcnt_nxt   = '0;
          pcnt_nxt   = PRE_OFF1;
          state_nxt  = ST_PRE_MUL;
        end
      end

      ST_PRE_MUL: begin
        if (pre_is_off) begin
          ma = {10'd0, {pre_off_mag, 16'd0} + 23'd50};
          mb = {9'd0, RECIP_100};
        end else begin
          ma = {1'b0, pre_vel_mag + 32'd5};
          mb = {1'b0, RECIP_10};
        end
        state_nxt = ST_PRE_FIN;
      end

      ST_PRE_FIN: begin
        pre_we = 1'b1;
        if (pcnt_r == PRE_LAST) begin
          if (nspawn_r == '0) begin
            idx_nxt   = '0;
            state_nxt = ST_SWP_RD;
          end else begin
            idx_nxt   = sstart_r;
            scnt_nxt  = '0;
            state_nxt = ST_SRCH_RD;
          end
        end else begin
          pcnt_nxt  = pcnt_r + 3'd1;
          state_nxt = ST_PRE_MUL;
        end
      end

      ST_SRCH_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = ST_SRCH_CHK;
      end

      ST_SRCH_CHK: begin
        if (rec_rd.life <= 0) begin
          tgt_nxt    = idx_r;
          sstart_nxt = idx_r;
          state_nxt  = ST_SPN_RD;
        end else if (scnt_r == SLOT_LAST) begin
          // every slot alive: fall back to slot zero
          tgt_nxt    = '0;
          sstart_nxt = '0;
          state_nxt  = ST_SPN_RD;
        end else begin
          idx_nxt   = idx_inc;
          scnt_nxt  = scnt_r + 1'b1;
          state_nxt = ST_SRCH_RD;
        end
      end

      ST_SPN_RD: begin
        rd_en     = 1'b1;
        rd_addr   = tgt_r;
        state_nxt = ST_SPN_WR;
      end

      ST_SPN_WR: begin
        wr_en        = 1'b1;
        wr_addr      = tgt_r;
        wr_rec.life  = LIFE_ONE;
        for (int a = 0; a < 3; a++) begin
          wr_rec.pos[a] = sat32($signed({{2{tpos_r[a][31]}}, tpos_r[a]}) +
                                $signed({{16{sp_offq[17]}}, sp_offq}));
        end
        wr_rec.vel   = svel_r;
        wr_rec.shade = SHADE_BASE + {1'b0, sp_shade};
        wr_rec.alpha = rec_rd.alpha;
        kcnt_nxt     = kcnt_r + 1'b1;
        if (kcnt_r + 1'b1 == nspawn_r) begin
          idx_nxt   = '0;
          state_nxt = ST_SWP_RD;
        end else begin
          idx_nxt   = sstart_r;
          scnt_nxt  = '0;
          state_nxt = ST_SRCH_RD;
        end
      end

      ST_SWP_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = ST_SWP_LIFE;
      end

      ST_SWP_LIFE: begin
        wrec_nxt      = rec_rd;
        wrec_nxt.life = life_n;
        ax_nxt        = '0;
        if (life_n > 0) begin
          wrec_nxt.alpha = life_n[16:0];
          state_nxt      = ST_SWP_MUL;
        end else begin
          state_nxt = ST_SWP_EMIT;
        end
      end

      ST_SWP_MUL: begin
        ma        = {wrec_r.vel[ax_r][31], wrec_r.vel[ax_r]};
        mb        = {17'd0, dt_r};
        state_nxt = ST_SWP_ACC;
      end

      ST_SWP_ACC: begin
        wrec_nxt.pos[ax_r] = sat32(pos_dif);
        if (ax_r == 2'd2) begin
          state_nxt = ST_SWP_EMIT;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = ST_SWP_MUL;
        end
      end

      ST_SWP_EMIT: begin
        if (emit_go) begin
          wr_en              = 1'b1;
          wr_addr            = idx_r;
          wr_rec             = wrec_r;
          out_valid_nxt      = 1'b1;
          out_nxt.slot       = SLOT_OUT_W'(idx_r);
          out_nxt.pos        = wrec_r.pos;
          out_nxt.alpha      = wrec_r.alpha;
          out_nxt.brightness = wrec_r.shade;
          out_nxt.alive      = (wrec_r.life > 0);
          out_nxt.last       = (idx_r == SLOT_LAST);
          if (idx_r == SLOT_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = ST_SWP_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      spawn_r     <= SPAWN_RESET;
      nspawn_r    <= '0;
      kcnt_r      <= '0;
      pcnt_r      <= '0;
      ax_r        <= '0;
      idx_r       <= '0;
      scnt_r      <= '0;
      sstart_r    <= '0;
      tgt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        spawn_r <= cfg_data;
      end
      nspawn_r    <= nspawn_nxt;
      kcnt_r      <= kcnt_nxt;
      pcnt_r      <= pcnt_nxt;
      ax_r        <= ax_nxt;
      idx_r       <= idx_nxt;
      scnt_r      <= scnt_nxt;
      sstart_r    <= sstart_nxt;
      tgt_r       <= tgt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wrec_r <= wrec_nxt;
    out_r  <= out_nxt;
    if (in_acc) begin
      dt_r      <= in_ch.dt;
      tpos_r[0] <= in_ch.target_pos_x;
      tpos_r[1] <= in_ch.target_pos_y;
      tpos_r[2] <= in_ch.target_pos_z;
      tvel_r[0] <= in_ch.target_vel_x;
      tvel_r[1] <= in_ch.target_vel_y;
      tvel_r[2] <= in_ch.target_vel_z;
      off1_r    <= in_ch.offset_first;
      shade1_r  <= in_ch.shade_first;
      off2_r    <= in_ch.offset_second;
      shade2_r  <= in_ch.shade_second;
    end
    if (pre_we) begin
      case (pcnt_r)
        PRE_OFF1: offq1_r <= pre_offq;
        PRE_OFF2: offq2_r <= pre_offq;
        default:  svel_r[pax] <= pre_svel;
      endcase
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      rd_q_r <= slot_mem[rd_addr];
    end
  end

  // valid bit per slot: unwritten slots read as reset record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.slot       = out_r.slot;
  assign out_ch.out_pos_x  = out_r.pos[0];
  assign out_ch.out_pos_y  = out_r.pos[1];
  assign out_ch.out_pos_z  = out_r.pos[2];
  assign out_ch.alpha      = out_r.alpha;
  assign out_ch.brightness = out_r.brightness;
  assign out_ch.alive      = out_r.alive;
  assign out_ch.last       = out_r.last;

  // spawns never run past the clamped count
  a_spawn_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH_RD || state_r == ST_SPN_WR) |-> (kcnt_r < nspawn_r))
    else $error("spawn counter past spawn count");

  a_nspawn_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (nspawn_r <= SPAWN_MAX))
    else $error("spawn count not clamped");

  // the last slot result ends the tick
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWP_EMIT && emit_go && idx_r == SLOT_LAST) |=> (state_r == ST_IDLE))
    else $error("sweep did not end after last slot");

  a_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWP_EMIT && out_valid_r && !out_ch.ready) |=>
    (state_r == ST_SWP_EMIT && $stable(idx_r)))
    else $error("sweep advanced while result stalled");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_PRE_MUL && !in_ch.ready))
    else $error("tick accepted without starting");

endmodule

`default_nettype wire
